// ===== rtl/gbab_pkg.sv =====
// Shared types and constants for the glyph blitter with alpha blend.
package gbab_pkg;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd2;

    localparam logic FMT_A8   = 1'b0;
    localparam logic FMT_ARGB = 1'b1;

    localparam int CFG_W     = 9;
    localparam int DIV_NUM_W = 26;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [7:0] BYTE_FULL = 8'hFF;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/gbab_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gbab_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/gbab_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module gbab_div (
    input  logic                clk,
    input  logic                rst_n,
    input  gbab_pkg::div_req_t  req,
    output gbab_pkg::div_rsp_t  rsp
);
    import gbab_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   shifted;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_DEN_W'(shifted - {1'b0, den_reg})
                            : shifted[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/glyph_blit_alpha_blend.sv =====
// Glyph blitter: draws clipped glyph bitmaps into a MAX_WIDTH x MAX_HEIGHT store of
// 32-bit pixel words, in single-byte coverage or ARGB32 form, with non-premultiplied
// over blending. Requests are taken one at a time; in_stall stays high while one is at
// work. A read holds in its last read state while the output slot is stalled. For each
// pixel position of a data byte: a position that is clipped, past the glyph width or a
// clear mono bit in single-byte form is skipped; a mono ARGB write stores the word
// directly; a single-byte OR is a read-modify-write through the store's one read port;
// an ARGB blend works the alpha out with a reciprocal multiply, then runs three
// divisions (red, green, blue) through the one shared divider; a blend whose alpha
// comes out zero writes zero. A mono byte handles its eight positions in turn. After
// reset and on every clear request the store is zeroed one word per cycle, all
// MAX_WIDTH*MAX_HEIGHT words (32768 by default), with requests stalled; config writes
// are taken at any time.
module glyph_blit_alpha_blend #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_write,
    input  logic [1:0]                   cfg_index,
    input  logic [gbab_pkg::CFG_W-1:0]   cfg_data,
    // request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   command,
    input  logic signed [9:0]            origin_x,
    input  logic signed [9:0]            origin_y,
    input  logic [7:0]                   glyph_width,
    input  logic [7:0]                   glyph_rows,
    input  logic [7:0]                   row_pitch,
    input  logic [23:0]                  text_color,
    input  logic                         smooth,
    input  logic [7:0]                   data_byte,
    input  logic [14:0]                  read_address,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [31:0]                  pixel_value
);
    import gbab_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    // effective clip sizes can never exceed what the config registers hold
    localparam int WCAP   = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int HCAP   = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PIX   = 4'd2;
    localparam logic [3:0] S_RD0   = 4'd3;
    localparam logic [3:0] S_RD1   = 4'd4;
    localparam logic [3:0] S_FETCH = 4'd5;
    localparam logic [3:0] S_MOD   = 4'd6;
    localparam logic [3:0] S_CMUL  = 4'd8;
    localparam logic [3:0] S_CSUM  = 4'd9;
    localparam logic [3:0] S_CDIV  = 4'd10;
    localparam logic [3:0] S_WRITE = 4'd11;
    localparam logic [3:0] S_NEXT  = 4'd12;

    // configuration
    logic [8:0]  fwidth_reg;
    logic [7:0]  fheight_reg;
    logic        fmt_reg;

    // glyph state latched by a begin request
    logic signed [9:0] gx_reg, gy_reg;
    logic [7:0]  gw_reg, gr_reg, pitch_reg;
    logic [23:0] color_reg;
    logic        smooth_reg;
    logic [7:0]  ccol_reg, crow_reg;

    // sequencer
    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] addr_reg, addr_next;
    logic          oor_reg, oor_next;
    logic [7:0]    byte_reg;
    logic [2:0]    bit_reg;
    logic [31:0]   dst_reg;
    logic [31:0]   wdata_reg, wdata_next;
    logic [7:0]    alpha_reg;
    logic [1:0]    ch_reg;
    logic [15:0]   p1_reg, p2_reg, den_reg;
    logic [23:0]   rgb_reg;

    logic          out_valid_reg;
    logic [31:0]   pixel_reg;

    // store ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic accept;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // clipping and addressing for the current glyph pixel
    logic [8:0]         clip_w;
    logic [7:0]         clip_h;
    logic [10:0]        col;
    logic signed [12:0] px;
    logic signed [10:0] py;
    logic               skip_col, clipped;
    logic [17:0]        lin;
    logic               mono_set;
    logic [7:0]         limit;
    logic [7:0]         inv_sa;
    logic [7:0]         s_ch, d_ch;
    logic [8:0]         chan_sat;
    logic [7:0]         chan;
    logic [15:0]        da_term;
    logic [15:0]        da_sum;
    logic [7:0]         alpha_calc;
    logic [23:0]        p2_scaled;

    assign clip_w   = (fwidth_reg > 9'(WCAP)) ? 9'(WCAP) : fwidth_reg;
    assign clip_h   = (fheight_reg > 8'(HCAP)) ? 8'(HCAP) : fheight_reg;
    assign col      = smooth_reg ? {3'b0, ccol_reg} : {ccol_reg, bit_reg};
    assign px       = 13'(gx_reg) + $signed({2'b0, col});
    assign py       = 11'(gy_reg) + $signed({3'b0, crow_reg});
    assign skip_col = !smooth_reg && (col >= {3'b0, gw_reg});
    assign clipped  = px[12] || py[10] || (px >= $signed({4'b0, clip_w}))
                      || (py >= $signed({3'b0, clip_h}));
    assign lin      = ({10'b0, py[7:0]} * {9'b0, clip_w}) + {9'b0, px[8:0]};
    assign mono_set = byte_reg[3'd7 - bit_reg];
    assign limit    = smooth_reg ? gw_reg : pitch_reg;
    assign inv_sa   = BYTE_FULL - byte_reg;

    // destination alpha term da*(255-sa)/255 by reciprocal: exact for 8-bit da and sa
    assign da_term    = ram_rdata[31:24] * inv_sa;
    assign da_sum     = da_term + {8'b0, da_term[15:8]} + 16'd1;
    assign alpha_calc = byte_reg + da_sum[15:8];

    always_comb
    begin
        case (ch_reg)
            2'd0:    begin s_ch = color_reg[23:16]; d_ch = dst_reg[23:16]; end
            2'd1:    begin s_ch = color_reg[15:8];  d_ch = dst_reg[15:8];  end
            default: begin s_ch = color_reg[7:0];   d_ch = dst_reg[7:0];   end
        endcase
    end

    assign chan_sat = (div_rsp.quotient > DIV_NUM_W'(255)) ? 9'd255
                                                           : div_rsp.quotient[8:0];
    assign chan     = chan_sat[7:0];

    assign p2_scaled = p2_reg * inv_sa;

    // divider requests: channel numerator from the registered products
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = 16'd255;
        if (state_reg == S_CSUM)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_NUM_W'({p1_reg, 8'b0} - {8'b0, p1_reg})
                             + DIV_NUM_W'(p2_scaled);
            div_req.divisor  = den_reg;
        end
    end

    gbab_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // store write mux: clearing sweep or pixel write
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = wdata_reg;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_WRITE)
        begin
            ram_we = 1'b1;
        end
    end

    gbab_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // next state and datapath selects
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        oor_next   = oor_reg;
        wdata_next = wdata_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_DATA:
                        begin
                            if (limit != 8'd0 && crow_reg < gr_reg)
                            begin
                                state_next = S_PIX;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        CMD_READ:
                        begin
                            addr_next  = AW'(read_address);
                            oor_next   = {17'b0, read_address} >= 32'(DEPTH);
                            state_next = S_RD0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                // hold until the output slot frees up
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PIX:
            begin
                addr_next = AW'(lin);
                if (skip_col || clipped)
                begin
                    state_next = S_NEXT;
                end
                else if (!smooth_reg && fmt_reg == FMT_ARGB)
                begin
                    wdata_next = {mono_set ? BYTE_FULL : 8'h00, color_reg};
                    state_next = S_WRITE;
                end
                else if (!smooth_reg && !mono_set)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (fmt_reg == FMT_A8)
                begin
                    wdata_next = ram_rdata
                               | {24'b0, smooth_reg ? byte_reg : BYTE_FULL};
                    state_next = S_WRITE;
                end
                else if (alpha_calc == 8'd0)
                begin
                    wdata_next = '0;
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_CMUL;
                end
            end
            S_CMUL:
            begin
                state_next = S_CSUM;
            end
            S_CSUM:
            begin
                state_next = S_CDIV;
            end
            S_CDIV:
            begin
                if (div_rsp.done)
                begin
                    if (ch_reg == 2'd2)
                    begin
                        wdata_next = {alpha_reg, rgb_reg[15:0], chan};
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_CMUL;
                    end
                end
            end
            S_WRITE:
            begin
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                state_next = (!smooth_reg && bit_reg != 3'd7) ? S_PIX : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            fwidth_reg    <= 9'd256;
            fheight_reg   <= 8'd128;
            fmt_reg       <= FMT_A8;
            gx_reg        <= '0;
            gy_reg        <= '0;
            gw_reg        <= '0;
            gr_reg        <= '0;
            pitch_reg     <= '0;
            color_reg     <= '0;
            smooth_reg    <= 1'b0;
            ccol_reg      <= '0;
            crow_reg      <= '0;
            bit_reg       <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  fwidth_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: fheight_reg <= cfg_data[7:0];
                    CFG_PIXEL_FORMAT: fmt_reg     <= cfg_data[0];
                    default:          fmt_reg     <= fmt_reg;
                endcase
            end

            // sweep runs on entry to the clearing state and restarts on clear
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            else
            begin
                clr_reg <= '0;
            end

            if (accept && command == CMD_BEGIN)
            begin
                gx_reg     <= origin_x;
                gy_reg     <= origin_y;
                gw_reg     <= glyph_width;
                gr_reg     <= glyph_rows;
                pitch_reg  <= row_pitch;
                color_reg  <= text_color;
                smooth_reg <= smooth;
                ccol_reg   <= '0;
                crow_reg   <= '0;
            end

            if (accept && command == CMD_DATA)
            begin
                bit_reg <= '0;
            end
            else if (state_reg == S_NEXT)
            begin
                if (!smooth_reg && bit_reg != 3'd7)
                begin
                    bit_reg <= bit_reg + 1'b1;
                end
                else if (ccol_reg + 8'd1 >= limit)
                begin
                    // advance to the next bitmap row
                    ccol_reg <= '0;
                    crow_reg <= crow_reg + 1'b1;
                end
                else
                begin
                    ccol_reg <= ccol_reg + 1'b1;
                end
            end

            if (state_reg == S_MOD)
            begin
                ch_reg <= '0;
            end
            else if (state_reg == S_CDIV && div_rsp.done)
            begin
                ch_reg <= ch_reg + 1'b1;
            end

            if (state_reg == S_RD1 && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        oor_reg   <= oor_next;
        wdata_reg <= wdata_next;
        if (accept && command == CMD_DATA)
        begin
            byte_reg <= data_byte;
        end
        if (state_reg == S_MOD)
        begin
            dst_reg   <= ram_rdata;
            alpha_reg <= alpha_calc;
        end
        if (state_reg == S_CMUL)
        begin
            p1_reg  <= s_ch * byte_reg;
            p2_reg  <= d_ch * dst_reg[31:24];
            den_reg <= 16'({alpha_reg, 8'b0} - {8'b0, alpha_reg});
        end
        if (state_reg == S_CDIV && div_rsp.done)
        begin
            rgb_reg <= {rgb_reg[15:0], chan};
        end
        if (state_reg == S_RD1 && (!out_valid_reg || !out_stall))
        begin
            pixel_reg <= oor_reg ? 32'd0 : ram_rdata;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_reg;

endmodule

// ===== rtl/gbab_checker.sv =====
// Port-level checker for the glyph blitter, bound to the top level.
module gbab_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  command,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] pixel_value
);
    import gbab_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pixel_value))
        else $error("stalled result changed");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command != CMD_READ |=> !$rose(out_valid))
        else $error("result without a read request");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_CLEAR |=> in_stall)
        else $error("clear request did not start a sweep");

endmodule

bind glyph_blit_alpha_blend gbab_checker u_gbab_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_value (pixel_value)
);
